// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the trace recorder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property check, disabled while reset is asserted.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`ASSERT_AT(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hw/rtl/trec_pkg.sv =====
// Shared types and constants of the trace event recorder.
// No dependencies; used by trec_intern and trace_event_recorder.
package trec_pkg;

	localparam int KEY_W     = 32;
	localparam int TS_W      = 32;
	localparam int PAYLOAD_W = 64;
	localparam int CFG_W     = 13;
	localparam int RADDR_W   = 12;
	localparam int BYTE_W    = 8;
	localparam int SCOPE_W   = 16;
	localparam int TOTAL_W   = 10;
	localparam int CNT_W     = 4;

	// Header is timestamp (4), scope id (2), type (1).
	localparam int HDR_BYTES     = 7;
	localparam int COUNTER_BYTES = 8;
	localparam int REC_BITS      = TS_W + SCOPE_W + BYTE_W + PAYLOAD_W;

	localparam logic [2:0] OP_ENTER      = 3'd0;
	localparam logic [2:0] OP_EXIT       = 3'd1;
	localparam logic [2:0] OP_COUNTER    = 3'd2;
	localparam logic [2:0] OP_FLOW_START = 3'd3;
	localparam logic [2:0] OP_FLOW_STEP  = 3'd4;
	localparam logic [2:0] OP_FLOW_END   = 3'd5;
	localparam logic [2:0] OP_CLEAR      = 3'd6;
	localparam logic [2:0] OP_READ       = 3'd7;

	// Word index of the buffer_size register on the APB port.
	localparam logic REG_BUFFER_SIZE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INTERN,
		ST_CHECK,
		ST_WRITE,
		ST_READ,
		ST_RESULT
	} rec_state_t;

	typedef enum logic {
		IS_IDLE,
		IS_SCAN
	} intern_state_t;

	typedef struct packed {
		logic             start;
		logic             has_cat;
		logic [KEY_W-1:0] cat_key;
		logic [KEY_W-1:0] name_key;
	} intern_req_t;

endpackage

// ===== hw/rtl/trec_intern.sv =====
// Name table and sequential lookup for the trace event recorder.
// Depends on trec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trec_intern
	import trec_pkg::*;
#(
	parameter int NAME_SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  intern_req_t           req,
	output logic                  done,
	output logic [((NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1)-1:0] id
);

	localparam int IW    = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;
	localparam int UW    = $clog2(NAME_SLOTS + 1);
	localparam int ENT_W = 1 + 2 * KEY_W;

	intern_state_t state_q, state_d;
	logic [UW-1:0] used_q, used_d;
	logic [UW-1:0] idx_q, idx_d;
	logic [UW-1:0] cmp_idx_s1, cmp_idx_d;
	logic          cmp_v_s1, cmp_v_d;
	logic [IW-1:0] id_q, id_d;
	logic          done_q, done_d;
	logic          rd_en, wr_en;
	logic [ENT_W-1:0] want;
	logic [ENT_W-1:0] ent_q;
	logic [ENT_W-1:0] tab_mem [NAME_SLOTS];

	// Entry layout: presence bit, category key (zero when absent), name key.
	assign want = {req.has_cat, (req.has_cat ? req.cat_key : {KEY_W{1'b0}}), req.name_key};

	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		idx_d     = idx_q;
		cmp_idx_d = idx_q;
		cmp_v_d   = 1'b0;
		id_d      = id_q;
		done_d    = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		unique case (state_q)
			IS_IDLE: begin
				if (req.start) begin
					if (used_q == '0) begin
						wr_en   = 1'b1;
						id_d    = '0;
						used_d  = UW'(1);
						done_d  = 1'b1;
					end else begin
						state_d = IS_SCAN;
						idx_d   = '0;
					end
				end
			end
			IS_SCAN: begin
				// Read one entry per cycle and compare the entry registered by the previous read.
				rd_en     = (idx_q < used_q);
				cmp_v_d   = rd_en;
				cmp_idx_d = idx_q;
				idx_d     = UW'(idx_q + 1'b1);
				if (cmp_v_s1 && (ent_q == want)) begin
					id_d    = IW'(cmp_idx_s1);
					done_d  = 1'b1;
					state_d = IS_IDLE;
				end else if (cmp_v_s1 && (cmp_idx_s1 == UW'(used_q - 1'b1))) begin
					done_d  = 1'b1;
					state_d = IS_IDLE;
					if (used_q < UW'(NAME_SLOTS)) begin
						wr_en  = 1'b1;
						id_d   = IW'(used_q);
						used_d = UW'(used_q + 1'b1);
					end else begin
						id_d = IW'(NAME_SLOTS - 1);
					end
				end
			end
			default: state_d = IS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IS_IDLE;
			used_q   <= '0;
			cmp_v_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			used_q   <= used_d;
			cmp_v_s1 <= cmp_v_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		cmp_idx_s1 <= cmp_idx_d;
		id_q       <= id_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tab_mem[IW'(used_q)] <= want;
		end
		if (rd_en) begin
			ent_q <= tab_mem[IW'(idx_q)];
		end
	end

	assign done = done_q;
	assign id   = id_q;

	`ASSERT_AT(a_used_bound, clk, arst_n, used_q <= UW'(NAME_SLOTS), "name table overfilled")
	`ASSERT_AT(a_done_pulse, clk, arst_n, done_q |=> !done_q, "lookup done held too long")
	`ASSERT_AT(a_append_one, clk, arst_n, wr_en |=> (used_q == UW'($past(used_q) + 1'b1)), "append did not grow table by one")

endmodule

// ===== hw/rtl/trace_event_recorder.sv =====
// Top level of the trace event recorder: stream ports, APB register, record writer.
// Depends on trec_pkg, trec_intern and assert_macros.svh.
//
// Usage. Event requests arrive on the s_ stream; every request yields exactly one
// result on the m_ stream. Enter, counter and flow requests first look up their
// key pair in the name table (appending it on a miss if there is room), then write a record of a
// 7-byte header plus payload bytes into the byte buffer, one byte per cycle
// through a byte shift register. Exit requests skip the lookup. Clear rewinds
// the buffer and keeps the names; read byte returns one stored buffer byte.
// Sequence: the lookup scans the interned names, then the fit check, then the
// record bytes (7 to 15) are written if the record fits, then the result is
// offered. Exit skips the lookup; clear goes straight to the result, and read
// byte reads the buffer once before it. The name table is scanned one entry per
// cycle and the byte buffer has a single write port. One request is in work at a
// time: s_tready is high only while idle, so the next request enters once the
// previous result has been taken. A stalled m_tready holds the result and the
// block. Reset clears fill position, record count, overflow flag, the name
// count and sets buffer_size to 4096; buffer and name storage are not cleared.
// APB address 0 holds buffer_size; the user must write it only while idle (unenforced).
`include "assert_macros.svh"

module trace_event_recorder
	import trec_pkg::*;
#(
	parameter int NAME_SLOTS    = 32,
	parameter int BUFFER_BYTES  = 4096,
	parameter int FLOW_ID_BYTES = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// category_key[31:0], name_key[63:32], exit_scope_id[68:64], payload[132:69],
	// timestamp[164:133], read_address[176:165], zero fill[183:177]
	input  logic [183:0] s_tdata,
	// opcode[2:0], category_present[3]
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// accepted[0], assigned_id[5:1], record_offset[17:6], write_position[30:18],
	// event_total[40:31], overflow_flag[41], read_data[49:42], zero fill[55:50]
	output logic [55:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IW  = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;
	localparam int AW  = $clog2(BUFFER_BYTES);
	// Largest usable size that a 13-bit buffer_size can reach in this buffer.
	localparam int CAP = (BUFFER_BYTES > 8191) ? 8191 : BUFFER_BYTES;
	localparam logic [CNT_W-1:0] SIZE_PLAIN   = CNT_W'(HDR_BYTES);
	localparam logic [CNT_W-1:0] SIZE_COUNTER = CNT_W'(HDR_BYTES + COUNTER_BYTES);
	localparam logic [CNT_W-1:0] SIZE_FLOW    = CNT_W'(HDR_BYTES + FLOW_ID_BYTES);

	// Input fields of the request.
	logic [2:0]           op_in;
	logic                 cat_p_in;
	logic [KEY_W-1:0]     cat_in, name_in;
	logic [4:0]           exit_in;
	logic signed [63:0]   payload_in;
	logic [TS_W-1:0]      ts_in;
	logic [RADDR_W-1:0]   addr_in;

	assign op_in      = s_tuser[2:0];
	assign cat_p_in   = s_tuser[3];
	assign cat_in     = s_tdata[31:0];
	assign name_in    = s_tdata[63:32];
	assign exit_in    = s_tdata[68:64];
	assign payload_in = signed'(s_tdata[132:69]);
	assign ts_in      = s_tdata[164:133];
	assign addr_in    = s_tdata[176:165];

	rec_state_t           state_q, state_d;
	logic [2:0]           op_q;
	logic                 cat_p_q;
	logic [KEY_W-1:0]     cat_q, name_q;
	logic signed [63:0]   payload_q;
	logic [TS_W-1:0]      ts_q;
	logic [RADDR_W-1:0]   addr_q;

	logic [CFG_W-1:0]     bsize_q;
	logic [CFG_W-1:0]     fill_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 ovf_q;
	logic                 start_q;

	logic [SCOPE_W-1:0]   hid_q;
	logic                 acc_q;
	logic [RADDR_W-1:0]   off_q;
	logic                 rsel_q;
	logic [BYTE_W-1:0]    rdat_q;
	logic [REC_BITS-1:0]  sr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CFG_W-1:0]     wa_q;
	logic [CFG_W-1:0]     p_q;

	logic                 s_acc;
	logic                 cfg_we;
	logic                 wr_en, rd_en;
	logic                 fit;
	logic                 in_range;
	logic [CNT_W-1:0]     size;
	logic [CFG_W-1:0]     limit;
	logic [CFG_W:0]       rec_end;
	intern_req_t          ireq;
	logic                 idone;
	logic [IW-1:0]        iid;
	logic [BYTE_W-1:0]    buf_mem [BUFFER_BYTES];

	assign s_acc  = s_tvalid && s_tready;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_BUFFER_SIZE);
	assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? 32'(bsize_q) : 32'd0;

	always_comb begin
		case (op_q) inside
			OP_COUNTER:                            size = SIZE_COUNTER;
			OP_FLOW_START, OP_FLOW_STEP, OP_FLOW_END: size = SIZE_FLOW;
			default:                               size = SIZE_PLAIN;
		endcase
	end

	// A record fits when its end does not pass the usable size. This also
	// rejects every record when the fill position already lies past the limit.
	assign limit    = (bsize_q > CFG_W'(CAP)) ? CFG_W'(CAP) : bsize_q;
	assign rec_end  = (CFG_W + 1)'(fill_q) + (CFG_W + 1)'(size);
	assign fit      = (rec_end <= (CFG_W + 1)'(limit));
	assign in_range = (32'(addr_q) < BUFFER_BYTES);

	// Category keys take part only in enter lookups.
	assign ireq.start    = start_q;
	assign ireq.has_cat  = (op_q == OP_ENTER) && cat_p_q;
	assign ireq.cat_key  = cat_q;
	assign ireq.name_key = name_q;

	trec_intern #(
		.NAME_SLOTS(NAME_SLOTS)
	) u_intern (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ireq),
		.done  (idone),
		.id    (iid)
	);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (op_in)
						OP_EXIT:  state_d = ST_CHECK;
						OP_CLEAR: state_d = ST_RESULT;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_INTERN;
					endcase
				end
			end
			ST_INTERN: begin
				if (idone) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = fit ? ST_WRITE : ST_RESULT;
			end
			ST_WRITE: begin
				wr_en = 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_RESULT;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state: sequencer, fill position, record count, overflow, register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bsize_q <= CFG_W'(4096);
			fill_q  <= '0;
			total_q <= '0;
			ovf_q   <= 1'b0;
			start_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			start_q <= s_acc && (op_in != OP_EXIT) && (op_in != OP_CLEAR) && (op_in != OP_READ);
			if (cfg_we) begin
				bsize_q <= pwdata[CFG_W-1:0];
			end
			if (s_acc && (op_in == OP_CLEAR)) begin
				fill_q  <= '0;
				total_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (state_q == ST_CHECK) begin
				if (fit) begin
					cnt_q <= size;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == ST_WRITE) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
				if (cnt_q == CNT_W'(1)) begin
					fill_q  <= CFG_W'(wa_q + 1'b1);
					total_q <= TOTAL_W'(total_q + 1'b1);
				end
			end
		end
	end

	// Request fields and the record datapath.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q      <= op_in;
			cat_p_q   <= cat_p_in;
			cat_q     <= cat_in;
			name_q    <= name_in;
			payload_q <= payload_in;
			ts_q      <= ts_in;
			addr_q    <= addr_in;
			acc_q     <= 1'b0;
			off_q     <= '0;
			rsel_q    <= 1'b0;
			hid_q     <= (op_in == OP_EXIT) ? SCOPE_W'(exit_in) : '0;
		end
		if ((state_q == ST_INTERN) && idone) begin
			hid_q <= SCOPE_W'(iid);
		end
		if ((state_q == ST_CHECK) && fit) begin
			p_q  <= fill_q;
			wa_q <= fill_q;
			sr_q <= {payload_q, BYTE_W'(op_q), hid_q, ts_q};
		end
		if (state_q == ST_WRITE) begin
			// Shift the next record byte down into the write lane.
			sr_q <= {{BYTE_W{1'b0}}, sr_q[REC_BITS-1:BYTE_W]};
			wa_q <= CFG_W'(wa_q + 1'b1);
			if (cnt_q == CNT_W'(1)) begin
				acc_q <= 1'b1;
				off_q <= p_q[RADDR_W-1:0];
			end
		end
		if (state_q == ST_READ) begin
			rsel_q <= in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[AW'(wa_q)] <= sr_q[BYTE_W-1:0];
		end
		if (rd_en) begin
			rdat_q <= buf_mem[AW'(addr_q)];
		end
	end

	assign m_tdata = {6'd0, (rsel_q ? rdat_q : {BYTE_W{1'b0}}), ovf_q, total_q, fill_q,
		off_q, hid_q[4:0], acc_q};

	`ASSERT_NEVER(a_one_side, clk, arst_n, s_tready && m_tvalid, "request taken while result pending")
	`ASSERT_AT(a_fill_cap, clk, arst_n, fill_q <= CFG_W'(CAP), "fill position beyond buffer")
	`ASSERT_AT(a_rec_len, clk, arst_n, ($rose(m_tvalid) && acc_q) |-> ((CFG_W + 1)'(fill_q) == ((CFG_W + 1)'(p_q) + (CFG_W + 1)'(size))), "record length mismatch")
	`ASSERT_AT(a_start_lookup, clk, arst_n, start_q |-> (state_q == ST_INTERN), "lookup started outside lookup state")

endmodule
